// ===== rtl/srp_pkg.sv =====
// Shared types, codes and helpers for the S19 record parser.
// Used by srp_step and srecord_s19_parser; depends on nothing.
package srp_pkg;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_ADDR  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_SKIP  = 3'd5;

	localparam logic [1:0] TYPE_S0 = 2'd0;
	localparam logic [1:0] TYPE_S1 = 2'd1;
	localparam logic [1:0] TYPE_S9 = 2'd2;

	localparam logic [2:0] KIND_DATA    = 3'd0;
	localparam logic [2:0] KIND_HEADER  = 3'd1;
	localparam logic [2:0] KIND_START   = 3'd2;
	localparam logic [2:0] KIND_BADLINE = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;
	localparam logic [2:0] KIND_BELOW   = 3'd5;

	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LFH  = 8'h66;
	localparam logic [7:0] HDR_LEN = 8'd3;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  rec_type;
		logic [3:0]  high_nibble;
		logic [2:0]  digit_count;
		logic [7:0]  bytes_left;
		logic [15:0] address_acc;
		logic        halted;
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] offset;
		logic [7:0]  data_byte;
		logic [15:0] start_address;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			h.val = 4'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UF) begin
			h.val = 4'(c - CH_UA + 8'd10);
		end else if (c >= CH_LA && c <= CH_LFH) begin
			h.val = 4'(c - CH_LA + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== rtl/srp_step.sv =====
// Next-state and result logic for one character of the S19 parser.
// Purely combinational; uses srp_pkg.
module srp_step (
	input  srp_pkg::state_t  st,
	input  logic [7:0]       c,
	input  logic [15:0]      base,
	output srp_pkg::state_t  nx,
	output logic             emit,
	output srp_pkg::result_t res
);

	srp_pkg::hex_t h;
	logic [15:0]   addr_shift;
	logic [7:0]    cnt;
	logic [7:0]    bl_dec;

	assign h          = srp_pkg::hex_value(c);
	assign addr_shift = {st.address_acc[11:0], h.val};
	assign cnt        = {st.high_nibble, h.val};
	assign bl_dec     = st.bytes_left - 8'd1;

	always_comb begin
		nx = st;
		emit = 1'b0;
		res = '0;
		if (st.halted) begin
			emit = 1'b0;
		end else if (st.phase == srp_pkg::PH_START) begin
			if (c != srp_pkg::CH_S) begin
				nx.halted = 1'b1;
				emit = 1'b1;
				res.kind = srp_pkg::KIND_BADLINE;
			end else begin
				nx.phase = srp_pkg::PH_TYPE;
			end
		end else if (c == srp_pkg::CH_LF) begin
			if (st.phase == srp_pkg::PH_TYPE) begin
				nx.halted = 1'b1;
				emit = 1'b1;
				res.kind = srp_pkg::KIND_UNKNOWN;
			end else begin
				nx.phase = srp_pkg::PH_START;
			end
		end else begin
			unique case (st.phase)
				srp_pkg::PH_TYPE: begin
					nx.digit_count = 3'd0;
					nx.address_acc = 16'd0;
					nx.bytes_left = 8'd0;
					if (c == srp_pkg::CH_0) begin
						nx.rec_type = srp_pkg::TYPE_S0;
						nx.phase = srp_pkg::PH_SKIP;
						emit = 1'b1;
						res.kind = srp_pkg::KIND_HEADER;
					end else if (c == srp_pkg::CH_1) begin
						nx.rec_type = srp_pkg::TYPE_S1;
						nx.phase = srp_pkg::PH_COUNT;
					end else if (c == srp_pkg::CH_9) begin
						nx.rec_type = srp_pkg::TYPE_S9;
						nx.phase = srp_pkg::PH_COUNT;
					end else begin
						nx.halted = 1'b1;
						emit = 1'b1;
						res.kind = srp_pkg::KIND_UNKNOWN;
					end
				end
				srp_pkg::PH_COUNT: begin
					if (!h.ok) begin
						nx.halted = 1'b1;
						emit = 1'b1;
						res.kind = srp_pkg::KIND_BADLINE;
					end else if (st.digit_count == 3'd0) begin
						nx.high_nibble = h.val;
						nx.digit_count = 3'd1;
					end else begin
						nx.bytes_left = (cnt >= srp_pkg::HDR_LEN) ? cnt - srp_pkg::HDR_LEN : 8'd0;
						nx.digit_count = 3'd0;
						nx.address_acc = 16'd0;
						nx.phase = srp_pkg::PH_ADDR;
					end
				end
				srp_pkg::PH_ADDR: begin
					if (!h.ok) begin
						nx.halted = 1'b1;
						emit = 1'b1;
						res.kind = srp_pkg::KIND_BADLINE;
					end else begin
						nx.address_acc = addr_shift;
						if (st.digit_count < 3'd3) begin
							nx.digit_count = st.digit_count + 3'd1;
						end else begin
							nx.digit_count = 3'd0;
							if (st.rec_type == srp_pkg::TYPE_S9) begin
								nx.phase = srp_pkg::PH_SKIP;
								emit = 1'b1;
								res.kind = srp_pkg::KIND_START;
								res.start_address = addr_shift;
							end else if (addr_shift < base) begin
								nx.halted = 1'b1;
								emit = 1'b1;
								res.kind = srp_pkg::KIND_BELOW;
							end else begin
								nx.phase = (st.bytes_left != 8'd0) ? srp_pkg::PH_DATA
								                                   : srp_pkg::PH_SKIP;
							end
						end
					end
				end
				srp_pkg::PH_DATA: begin
					if (!h.ok) begin
						nx.halted = 1'b1;
						emit = 1'b1;
						res.kind = srp_pkg::KIND_BADLINE;
					end else if (st.digit_count == 3'd0) begin
						nx.high_nibble = h.val;
						nx.digit_count = 3'd1;
					end else begin
						nx.digit_count = 3'd0;
						nx.address_acc = st.address_acc + 16'd1;
						nx.bytes_left = bl_dec;
						if (bl_dec == 8'd0) begin
							nx.phase = srp_pkg::PH_SKIP;
						end
						emit = 1'b1;
						res.kind = srp_pkg::KIND_DATA;
						res.offset = st.address_acc - base;
						res.data_byte = cnt;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/srecord_s19_parser.sv =====
// Top level of the S19 record parser: input register, parse state and result register.
// Path: a character is registered in char_s1, and its result in res_s2, which drives the outputs.
// Throughput: one char per cycle unless out_stall holds it; single-step parse in srp_step.
// Reset: arst_n clears the parse state, base address and both stage valids at once.
// Uses srp_pkg and srp_step.
module srecord_s19_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [15:0] offset,
	output logic [7:0]  data_byte,
	output logic [15:0] start_address,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             valid_s2;
	srp_pkg::result_t res_s2;
	srp_pkg::state_t  state_q;
	srp_pkg::state_t  state_nx;
	srp_pkg::result_t res_nx;
	logic             emit_nx;
	logic [15:0]      base_q;
	logic             adv_s2;
	logic             adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	srp_step u_step (
		.st   (state_q),
		.c    (char_s1),
		.base (base_q),
		.nx   (state_nx),
		.emit (emit_nx),
		.res  (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			base_q <= 16'd0;
			state_q <= '{phase: srp_pkg::PH_START, default: '0};
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= adv_s1 && emit_nx;
			end
			if (adv_s1) begin
				state_q <= state_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_in;
		end
		if (adv_s1 && emit_nx) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid     = valid_s2;
	assign result_kind   = res_s2.kind;
	assign offset        = res_s2.offset;
	assign data_byte     = res_s2.data_byte;
	assign start_address = res_s2.start_address;

endmodule
